/* hdl/sccr_pkg.sv */
// Shared types and constants for the sector cache replacement engine.
package sccr_pkg;

	localparam int ENTRIES = 64;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	localparam logic [1:0] ACT_READ  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_FLUSH = 2'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] sector;
	} in_item_t;

	typedef struct packed {
		logic [5:0]  entry_index;
		logic        hit;
		logic        fetch_needed;
		logic        writeback_needed;
		logic [31:0] writeback_sector;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic             valid;
		logic             dirty;
		logic             recent;
		logic [31:0]      tag;
		logic [IDX_W-1:0] idx;
	} entry_t;

	typedef struct packed {
		logic set_recent;
		logic clr_recent;
		logic set_dirty;
		logic clr_dirty;
		logic load;
		logic load_dirty;
	} edit_t;

endpackage

/* hdl/sccr_cell.sv */
// One ring cell: holds a cache entry and takes its neighbor's entry on a shift.
module sccr_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [sccr_pkg::IDX_W-1:0] rst_idx,
	input  logic                  shift,
	input  sccr_pkg::entry_t      nb,
	input  sccr_pkg::edit_t       edit,
	input  logic [31:0]           key,
	output sccr_pkg::entry_t      q,
	output logic                  match
);
	import sccr_pkg::*;

	entry_t ent_q;
	entry_t d;

	// Edits are applied to the entry as it moves into this cell.
	always_comb begin
		d = nb;
		if (edit.set_recent) d.recent = 1'b1;
		if (edit.clr_recent) d.recent = 1'b0;
		if (edit.set_dirty)  d.dirty  = 1'b1;
		if (edit.clr_dirty)  d.dirty  = 1'b0;
		if (edit.load) begin
			d.tag    = key;
			d.valid  = 1'b1;
			d.recent = 1'b1;
			d.dirty  = edit.load_dirty;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '{valid: 1'b0, dirty: 1'b0, recent: 1'b0, tag: 32'd0, idx: rst_idx};
		end else if (shift) begin
			ent_q <= d;
		end
	end

	assign q     = ent_q;
	assign match = ent_q.valid && (ent_q.tag == key);
endmodule

/* hdl/sector_cache_clock_replacement.sv */
// Top level of the sector cache tag and clock replacement engine.
// Usage: an input transaction carries an action (read, write, flush) and a
// sector number. Input stall is high whenever an action is in progress, so
// the block works on one transaction at a time. Read and write produce one
// result transaction; a flush produces one per valid dirty entry, with last
// set on the final one, and none if nothing is dirty. Unused action code 3
// is accepted and ignored.
// The entries live in a ring of cells that rotates by one place per cycle while
// a lookup, miss or flush runs, unless a flush halts it; the cell at the head is
// examined and edited as it wraps to the tail. A lookup takes one full turn of
// the ring. A miss then rotates one or two full turns more, until the victim is
// found and the ring is aligned again. A flush takes one full turn. The output
// register is then loaded with the result of a read or write in ST_EMIT.
// Reset clears all marks, aligns the ring and sets the clock hand to zero.
// While the receiver stalls, the result holds in the output register; a
// flush halts its rotation when it has a new result and nowhere to put it.
module sector_cache_clock_replacement (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  sccr_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output sccr_pkg::out_item_t out_data
);
	import sccr_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_LOOK  = 6'b000010,
		ST_SWEEP = 6'b000100,
		ST_FLUSH = 6'b001000,
		ST_FEND  = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	state_t           state_q;
	logic [1:0]       action_q;
	logic [31:0]      sector_q;
	logic [IDX_W-1:0] cnt_q;
	logic [IDX_W-1:0] hand_q;
	logic             found_q;
	logic             started_q;
	logic             done_q;
	logic             pend_valid_q;
	out_item_t        pend_q;
	out_item_t        res_q;
	logic             out_valid_q;
	out_item_t        out_q;

	entry_t           ent [ENTRIES];
	logic [ENTRIES-1:0] match;
	logic             shift;
	edit_t            tail_edit;

	entry_t head;
	assign head = ent[0];

	// The ring: cell i takes the entry of cell i+1, the tail takes the head.
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		edit_t e;
		if (i == ENTRIES - 1) begin : g_tail
			assign e = tail_edit;
		end else begin : g_body
			assign e = '0;
		end
		sccr_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.rst_idx (IDX_W'(i)),
			.shift   (shift),
			.nb      (ent[(i + 1) % ENTRIES]),
			.edit    (e),
			.key     (sector_q),
			.q       (ent[i]),
			.match   (match[i])
		);
	end

	logic out_free;
	assign out_free = !out_valid_q || !out_stall;

	logic hit_now;
	logic dirty_now;
	logic sweep_active;
	assign hit_now      = match[0] && !found_q;
	assign dirty_now    = head.valid && head.dirty;
	assign sweep_active = !done_q && (started_q || head.idx == hand_q);

	logic [5:0] head_idx6;
	assign head_idx6 = 6'(head.idx);

	// The final flush result is the held one with its last flag raised.
	out_item_t pend_last;
	always_comb begin
		pend_last      = pend_q;
		pend_last.last = 1'b1;
	end

	always_comb begin
		shift     = 1'b0;
		tail_edit = '0;
		unique case (state_q)
			ST_LOOK: begin
				shift                = 1'b1;
				tail_edit.set_recent = hit_now;
				tail_edit.set_dirty  = hit_now && (action_q == ACT_WRITE);
			end
			ST_SWEEP: begin
				if (!(done_q && head.idx == '0)) begin
					shift = 1'b1;
					if (sweep_active) begin
						tail_edit.clr_recent = head.recent;
						tail_edit.load       = !head.recent;
						tail_edit.load_dirty = (action_q == ACT_WRITE);
					end
				end
			end
			ST_FLUSH: begin
				if (!(dirty_now && pend_valid_q && !out_free)) begin
					shift               = 1'b1;
					tail_edit.clr_dirty = dirty_now;
				end
			end
			default: ;
		endcase
	end

	// High in any cycle that loads a new result into the output register.
	logic out_load;
	assign out_load = (state_q == ST_FLUSH && shift && dirty_now && pend_valid_q) ||
	                  (state_q == ST_FEND && pend_valid_q && out_free) ||
	                  (state_q == ST_EMIT && out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			hand_q       <= '0;
			found_q      <= 1'b0;
			started_q    <= 1'b0;
			done_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !out_load) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cnt_q   <= '0;
						found_q <= 1'b0;
						if (in_data.action == ACT_FLUSH) begin
							state_q <= ST_FLUSH;
						end else if (in_data.action == ACT_READ ||
						             in_data.action == ACT_WRITE) begin
							state_q <= ST_LOOK;
						end
					end
				end
				ST_LOOK: begin
					cnt_q <= (cnt_q == IDX_W'(ENTRIES - 1)) ? '0 : cnt_q + 1'b1;
					if (hit_now) found_q <= 1'b1;
					if (cnt_q == IDX_W'(ENTRIES - 1)) begin
						if (found_q || hit_now) begin
							state_q <= ST_EMIT;
						end else begin
							state_q   <= ST_SWEEP;
							started_q <= 1'b0;
							done_q    <= 1'b0;
						end
					end
				end
				ST_SWEEP: begin
					if (done_q && head.idx == '0) begin
						state_q <= ST_EMIT;
					end else if (sweep_active) begin
						started_q <= 1'b1;
						if (!head.recent) begin
							done_q <= 1'b1;
							hand_q <= (head.idx == IDX_W'(ENTRIES - 1)) ? '0
							          : head.idx + 1'b1;
						end
					end
				end
				ST_FLUSH: begin
					if (shift) begin
						cnt_q <= (cnt_q == IDX_W'(ENTRIES - 1)) ? '0 : cnt_q + 1'b1;
						if (dirty_now) begin
							if (pend_valid_q) out_valid_q <= 1'b1;
							pend_valid_q <= 1'b1;
						end
						if (cnt_q == IDX_W'(ENTRIES - 1)) begin
							state_q <= ST_FEND;
						end
					end
				end
				ST_FEND: begin
					if (!pend_valid_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_valid_q  <= 1'b1;
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					action_q <= in_data.action;
					sector_q <= in_data.sector;
				end
			end
			ST_LOOK: begin
				if (hit_now) begin
					res_q <= '{entry_index: head_idx6, hit: 1'b1, fetch_needed: 1'b0,
					           writeback_needed: 1'b0, writeback_sector: 32'd0,
					           last: 1'b1};
				end
			end
			ST_SWEEP: begin
				if (!(done_q && head.idx == '0) && sweep_active && !head.recent) begin
					res_q <= '{entry_index: head_idx6, hit: 1'b0, fetch_needed: 1'b1,
					           writeback_needed: dirty_now,
					           writeback_sector: dirty_now ? head.tag : 32'd0,
					           last: 1'b1};
				end
			end
			ST_FLUSH: begin
				if (shift && dirty_now) begin
					if (pend_valid_q) out_q <= pend_q;
					pend_q <= '{entry_index: head_idx6, hit: 1'b0, fetch_needed: 1'b0,
					            writeback_needed: 1'b1, writeback_sector: head.tag,
					            last: 1'b0};
				end
			end
			ST_FEND: begin
				if (pend_valid_q && out_free) begin
					out_q <= pend_last;
				end
			end
			ST_EMIT: begin
				if (out_free) out_q <= res_q;
			end
			default: ;
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	// The ring is always back in its home alignment between transactions.
	a_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> ent[0].idx == '0)
		else $error("ring not aligned while idle");

	// The clock hand never points past the last entry.
	a_hand: assert property (@(posedge clk) disable iff (!arst_n)
		hand_q <= IDX_W'(ENTRIES - 1))
		else $error("clock hand out of range");

	// A held flush result only exists while a flush is running.
	a_pend: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> (state_q == ST_FLUSH || state_q == ST_FEND))
		else $error("pending flush result outside flush");

	// A new result is only produced by a result-producing state.
	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_EMIT || $past(state_q) == ST_FEND
		                        || $past(state_q) == ST_FLUSH))
		else $error("result from unexpected state");
`endif
endmodule
